/* sv/lru_tag_directory_macros.svh */
// assertion helpers shared by the checker
`ifndef LRU_TAG_DIRECTORY_MACROS_SVH
`define LRU_TAG_DIRECTORY_MACROS_SVH

// same-cycle implication
`define LRUTD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRUTD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lrutd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lrutd_pkg;
  localparam int MAX_LINES  = 128;
  localparam int LAYER_BITS = 16;
  localparam int STAMP_BITS = 48;
  localparam int IDX_W      = $clog2(MAX_LINES);
  localparam int NUM_W      = $clog2(MAX_LINES + 1);
  localparam int CNT_W      = 32;
  localparam int OUT_IDX_W  = 7;

  typedef enum logic [1:0] {
    FN_LOOKUP   = 2'd0,
    FN_PROBE    = 2'd1,
    FN_PREFETCH = 2'd2,
    FN_FLUSH    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  localparam logic [2:0] REG_LINES_ADDR = 3'd0;

  // partial search result handed from cell to cell
  typedef struct packed {
    logic                  found;
    logic [IDX_W-1:0]      fidx;
    logic                  inv;
    logic [IDX_W-1:0]      iidx;
    logic [STAMP_BITS-1:0] bstamp;
    logic [IDX_W-1:0]      bidx;
  } carry_t;

  // line update broadcast from the controller
  typedef struct packed {
    logic                  flush;
    logic                  we;
    logic                  fill;
    logic [IDX_W-1:0]      idx;
    logic [STAMP_BITS-1:0] stamp;
    logic [7:0]            model;
    logic [LAYER_BITS-1:0] layer;
  } upd_t;
endpackage
`default_nettype wire

/* sv/lru_tag_directory.sv */
// a flush goes straight to the finish state; other operations first scan every line cell
// one item at a time; the search wave walks the row of line cells, one per cycle
// a new item is taken only after the result of the last one has been registered
// reset: all lines invalid, counters and access clock zero, lines_in_use 128
`timescale 1ns / 1ps
`default_nettype none
module lru_tag_directory (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  model_id_i,
  input  logic [15:0] layer_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic        victim_evicted_o,
  output logic [6:0]  line_index_o,
  output logic [31:0] hit_count_o,
  output logic [31:0] miss_count_o,
  output logic [31:0] eviction_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lrutd_pkg::*;

  state_e                state_q, state_d;
  logic [7:0]            lines_q;
  logic [NUM_W-1:0]      n_eff;
  func_e                 op_q;
  logic [7:0]            model_q;
  logic [LAYER_BITS-1:0] layer_q;
  logic [STAMP_BITS-1:0] clock_q, clock_d;
  logic [CNT_W-1:0]      hits_q, hits_d, miss_q, miss_d, evict_q, evict_d;
  logic                  out_valid_q;
  logic                  hit_q, victim_q;
  logic [OUT_IDX_W-1:0]  idx_q;
  logic                  hit_d, victim_d;
  logic [IDX_W-1:0]      idx_d;
  logic                  accept, fin_go;
  logic                  start_q;
  logic [MAX_LINES:0]    wave;
  carry_t                chain [MAX_LINES+1];
  upd_t                  upd;
  carry_t                res;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_LINES_ADDR) ? {24'd0, lines_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_q <= 8'd128;
    end else if (psel && penable && pwrite && paddr == REG_LINES_ADDR) begin
      lines_q <= pwdata[7:0];
    end
  end

  always_comb begin
    if (lines_q == 8'd0) begin
      n_eff = NUM_W'(1);
    end else if (32'(lines_q) > MAX_LINES) begin
      n_eff = NUM_W'(MAX_LINES);
    end else begin
      n_eff = NUM_W'(lines_q);
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign fin_go     = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  // the wave starts once the tags of the item are registered
  assign wave[0]  = start_q;
  assign chain[0] = '0;

  for (genvar g = 0; g < MAX_LINES; g++) begin : g_cell
    lrutd_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (IDX_W'(g)),
      .in_use_i (NUM_W'(g) < n_eff),
      .model_i  (model_q),
      .layer_i  (layer_q),
      .wave_i   (wave[g]),
      .carry_i  (chain[g]),
      .upd_i    (upd),
      .wave_o   (wave[g+1]),
      .carry_o  (chain[g+1])
    );
  end

  assign res = chain[MAX_LINES];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = (func_e'(func_i) == FN_FLUSH) ? ST_FIN : ST_SCAN;
      ST_SCAN: if (wave[MAX_LINES]) state_d = ST_FIN;
      ST_FIN:  if (fin_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    upd      = '0;
    upd.model = model_q;
    upd.layer = layer_q;
    upd.stamp = clock_q;
    clock_d  = clock_q;
    hits_d   = hits_q;
    miss_d   = miss_q;
    evict_d  = evict_q;
    hit_d    = 1'b0;
    victim_d = 1'b0;
    idx_d    = '0;
    if (op_q == FN_FLUSH) begin
      upd.flush = fin_go;
    end else begin
      if (res.found) begin
        hit_d = 1'b1;
        idx_d = res.fidx;
      end
      if (op_q == FN_LOOKUP) begin
        if (res.found) begin
          upd.we  = fin_go;
          upd.idx = res.fidx;
          clock_d = clock_q + 1'b1;
          if (hits_q != '1) hits_d = hits_q + 1'b1;
        end else if (miss_q != '1) begin
          miss_d = miss_q + 1'b1;
        end
      end else if (op_q == FN_PREFETCH && !res.found) begin
        upd.we   = fin_go;
        upd.fill = 1'b1;
        upd.idx  = res.inv ? res.iidx : res.bidx;
        idx_d    = upd.idx;
        clock_d  = clock_q + 1'b1;
        if (!res.inv) begin
          victim_d = 1'b1;
          if (evict_q != '1) evict_d = evict_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      clock_q     <= '0;
      hits_q      <= '0;
      miss_q      <= '0;
      evict_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= accept && (func_e'(func_i) != FN_FLUSH);
      if (fin_go) begin
        clock_q     <= clock_d;
        hits_q      <= hits_d;
        miss_q      <= miss_d;
        evict_q     <= evict_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= func_e'(func_i);
      model_q <= model_id_i;
      layer_q <= layer_id_i[LAYER_BITS-1:0];
    end
    if (fin_go) begin
      hit_q    <= hit_d;
      victim_q <= victim_d;
      idx_q    <= OUT_IDX_W'(idx_d);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_q;
  assign victim_evicted_o = victim_q;
  assign line_index_o     = idx_q;
  assign hit_count_o      = hits_q;
  assign miss_count_o     = miss_q;
  assign eviction_count_o = evict_q;
endmodule
`default_nettype wire

/* sv/lrutd_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module lrutd_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [lrutd_pkg::IDX_W-1:0]     idx_i,
  input  logic                            in_use_i,
  input  logic [7:0]                      model_i,
  input  logic [lrutd_pkg::LAYER_BITS-1:0] layer_i,
  input  logic                            wave_i,
  input  lrutd_pkg::carry_t               carry_i,
  input  lrutd_pkg::upd_t                 upd_i,
  output logic                            wave_o,
  output lrutd_pkg::carry_t               carry_o
);
  import lrutd_pkg::*;

  logic                  valid_q;
  logic [7:0]            model_q;
  logic [LAYER_BITS-1:0] layer_q;
  logic [STAMP_BITS-1:0] stamp_q;
  logic                  wave_q;
  carry_t                carry_q, carry_d;

  always_comb begin
    carry_d = carry_i;
    if (in_use_i) begin
      if (!carry_i.found && valid_q && model_q == model_i && layer_q == layer_i) begin
        carry_d.found = 1'b1;
        carry_d.fidx  = idx_i;
      end
      if (!carry_i.inv && !valid_q) begin
        carry_d.inv  = 1'b1;
        carry_d.iidx = idx_i;
      end
      // strict less keeps the lowest index among equal stamps
      if (idx_i == '0 || stamp_q < carry_i.bstamp) begin
        carry_d.bstamp = stamp_q;
        carry_d.bidx   = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      wave_q  <= 1'b0;
    end else begin
      wave_q <= wave_i;
      if (upd_i.flush) begin
        valid_q <= 1'b0;
      end else if (upd_i.we && upd_i.fill && upd_i.idx == idx_i) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wave_i) begin
      carry_q <= carry_d;
    end
    if (!upd_i.flush && upd_i.we && upd_i.idx == idx_i) begin
      stamp_q <= upd_i.stamp;
      if (upd_i.fill) begin
        model_q <= upd_i.model;
        layer_q <= upd_i.layer;
      end
    end
  end

  assign wave_o  = wave_q;
  assign carry_o = carry_q;
endmodule
`default_nettype wire

/* sv/lrutd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "lru_tag_directory_macros.svh"
module lrutd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  func_i,
  input logic [7:0]  model_id_i,
  input logic [15:0] layer_id_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        hit_o,
  input logic        victim_evicted_o,
  input logic [6:0]  line_index_o,
  input logic [31:0] hit_count_o,
  input logic [31:0] miss_count_o,
  input logic [31:0] eviction_count_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);
  // a stalled result keeps its line index
  `LRUTD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(line_index_o), "stalled result changed")
  // one item at a time
  `LRUTD_ASSERT_NXT(a_busy, clk_i, rst_ni, in_valid_i && !in_stall_o,
    in_stall_o, "item taken while busy")
  // an eviction only happens on a prefetch miss
  `LRUTD_ASSERT_IMP(a_evict_miss, clk_i, rst_ni, out_valid_o && victim_evicted_o,
    !hit_o, "eviction reported with a hit")
  // the hit counter never runs backward
  `LRUTD_ASSERT_NXT(a_hits_mono, clk_i, rst_ni, 1'b1,
    hit_count_o >= $past(hit_count_o), "hit count decreased")
endmodule

bind lru_tag_directory lrutd_checker u_lrutd_checker (.*);
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
module tb;
  import lrutd_pkg::*;

  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic [6:0]  idx;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evictions;
  } dir_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  func_i;
  logic [7:0]  model_id_i;
  logic [15:0] layer_id_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        hit_o;
  logic        victim_evicted_o;
  logic [6:0]  line_index_o;
  logic [31:0] hit_count_o;
  logic [31:0] miss_count_o;
  logic [31:0] eviction_count_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lru_tag_directory dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the directory
  logic                  dir_valid [MAX_LINES];
  logic [7:0]            dir_model [MAX_LINES];
  logic [15:0]           dir_layer [MAX_LINES];
  logic [STAMP_BITS-1:0] dir_stamp [MAX_LINES];
  logic [STAMP_BITS-1:0] dir_clock;
  logic [31:0]           dir_hits, dir_misses, dir_evictions;
  logic [7:0]            dir_lines_cfg;

  dir_result_t expected_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold = 0;

  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  task automatic predict_directory(func_e fn, logic [7:0] model, logic [15:0] layer);
    dir_result_t r;
    int n;
    int where;
    int victim;
    r = '0;
    where = -1;
    n = (dir_lines_cfg == 0) ? 1 : (dir_lines_cfg > MAX_LINES ? MAX_LINES : dir_lines_cfg);
    if (fn == FN_FLUSH) begin
      for (int i = 0; i < MAX_LINES; i++) dir_valid[i] = 1'b0;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (where < 0 && dir_valid[i] && dir_model[i] == model && dir_layer[i] == layer)
          where = i;
      end
      if (where >= 0) begin
        r.hit = 1'b1;
        r.idx = where[6:0];
      end
      if (fn == FN_LOOKUP) begin
        if (where >= 0) begin
          dir_stamp[where] = dir_clock;
          dir_clock = dir_clock + 1'b1;
          dir_hits = sat_inc(dir_hits);
        end else begin
          dir_misses = sat_inc(dir_misses);
        end
      end else if (fn == FN_PREFETCH && where < 0) begin
        victim = -1;
        for (int i = 0; i < n; i++) begin
          if (victim < 0 && !dir_valid[i]) victim = i;
        end
        if (victim < 0) begin
          victim = 0;
          for (int i = 1; i < n; i++) begin
            if (dir_stamp[i] < dir_stamp[victim]) victim = i;
          end
          r.evicted = 1'b1;
          dir_evictions = sat_inc(dir_evictions);
        end
        dir_model[victim] = model;
        dir_layer[victim] = layer;
        dir_stamp[victim] = dir_clock;
        dir_clock = dir_clock + 1'b1;
        dir_valid[victim] = 1'b1;
        r.idx = victim[6:0];
      end
    end
    r.hits = dir_hits;
    r.misses = dir_misses;
    r.evictions = dir_evictions;
    expected_q.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // sends one item; valid stays high on return
  task automatic send_item(func_e fn, logic [7:0] model, logic [15:0] layer);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= fn;
    model_id_i <= model;
    layer_id_i <= layer;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    predict_directory(fn, model, layer);
  endtask

  // lets the block finish before a register write
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (MAX_LINES + 12) @(posedge clk_i);
  endtask

  task automatic write_lines(logic [7:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= REG_LINES_ADDR;
    pwdata <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    dir_lines_cfg = value;
    @(posedge clk_i);
  endtask

  // receiver: stall pattern and result check
  initial begin
    dir_result_t got, want;
    logic taken;
    forever begin
      @(negedge clk_i);
      taken = rst_ni && out_valid_o && !out_stall_i;
      got = {hit_o, victim_evicted_o, line_index_o, hit_count_o, miss_count_o,
             eviction_count_o};
      @(posedge clk_i);
      if (recv_hold > 0) begin
        recv_hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
      if (taken) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 32'd0, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (got.hit !== want.hit)
            report_mismatch("hit", 32'(got.hit), 32'(want.hit));
          if (got.evicted !== want.evicted)
            report_mismatch("victim_evicted", 32'(got.evicted), 32'(want.evicted));
          if (got.idx !== want.idx)
            report_mismatch("line_index", 32'(got.idx), 32'(want.idx));
          if (got.hits !== want.hits) report_mismatch("hit_count", got.hits, want.hits);
          if (got.misses !== want.misses)
            report_mismatch("miss_count", got.misses, want.misses);
          if (got.evictions !== want.evictions)
            report_mismatch("eviction_count", got.evictions, want.evictions);
        end
      end
    end
  end

  task automatic test_directed();
    write_lines(8'd4);
    send_item(FN_PREFETCH, 8'd0, 16'd0);
    send_item(FN_PREFETCH, 8'd255, 16'hFFFF);
    send_item(FN_LOOKUP, 8'd255, 16'hFFFF);
    send_item(FN_PROBE, 8'd0, 16'd0);
    send_item(FN_LOOKUP, 8'd0, 16'hFFFF);
    send_item(FN_PROBE, 8'hAA, 16'h5555);
    send_item(FN_PREFETCH, 8'd0, 16'd0);
    send_item(FN_PREFETCH, 8'd1, 16'd1);
    send_item(FN_PREFETCH, 8'd2, 16'd2);
    send_item(FN_LOOKUP, 8'd0, 16'd0);
    // full set: least recent line gets replaced
    send_item(FN_PREFETCH, 8'd3, 16'd3);
    send_item(FN_PREFETCH, 8'd4, 16'd4);
    wait_idle();
    // lines beyond the count keep their tags
    write_lines(8'd2);
    send_item(FN_LOOKUP, 8'd2, 16'd2);
    send_item(FN_PREFETCH, 8'd5, 16'd5);
    wait_idle();
    write_lines(8'd4);
    send_item(FN_LOOKUP, 8'd2, 16'd2);
    send_item(FN_FLUSH, 8'd0, 16'd0);
    send_item(FN_LOOKUP, 8'd2, 16'd2);
    wait_idle();
    write_lines(8'd0);
    send_item(FN_PREFETCH, 8'd7, 16'd7);
    send_item(FN_PREFETCH, 8'd8, 16'd8);
    send_item(FN_PROBE, 8'd7, 16'd7);
    wait_idle();
    write_lines(8'd255);
    send_item(FN_PREFETCH, 8'h55, 16'hAAAA);
    send_item(FN_LOOKUP, 8'd8, 16'd8);
    wait_idle();
  endtask

  task automatic test_random(logic [7:0] lines, int count, bit pressure);
    int tag_max;
    int pick;
    func_e fn;
    logic [7:0] model;
    logic [15:0] layer;
    write_lines(lines);
    tag_max = (lines > 16) ? 15 : 3;
    if (pressure) recv_hold = 700;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      fn = (pick < 40) ? FN_LOOKUP : (pick < 55) ? FN_PROBE :
           (pick < 96) ? FN_PREFETCH : FN_FLUSH;
      if ($urandom_range(9) == 0) begin
        model = 8'($urandom);
        layer = 16'($urandom);
      end else begin
        model = 8'($urandom_range(tag_max));
        layer = 16'($urandom_range(tag_max));
      end
      send_item(fn, model, layer);
    end
    wait_idle();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i <= 1'b0;
    func_i <= FN_LOOKUP;
    model_id_i <= '0;
    layer_id_i <= '0;
    out_stall_i <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    for (int i = 0; i < MAX_LINES; i++) begin
      dir_valid[i] = 1'b0;
      dir_model[i] = '0;
      dir_layer[i] = '0;
      dir_stamp[i] = '0;
    end
    dir_clock = '0;
    dir_hits = '0;
    dir_misses = '0;
    dir_evictions = '0;
    dir_lines_cfg = 8'd128;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset default of 128 lines first
    send_item(FN_PREFETCH, 8'd9, 16'd9);
    send_item(FN_LOOKUP, 8'd9, 16'd9);
    wait_idle();
    test_directed();
    send_idle_pct = 9;
    recv_idle_pct = 58;
    test_random(8'd3, 260, 1'b0);
    test_random(8'd8, 260, 1'b1);
    send_idle_pct = 58;
    recv_idle_pct = 9;
    test_random(8'd1, 260, 1'b0);
    test_random(8'd128, 270, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(8'd0, 260, 1'b0);
    test_random(8'd255, 270, 1'b0);
    test_random(8'd16, 270, 1'b0);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+sv
sv/lrutd_pkg.sv
sv/lrutd_cell.sv
sv/lru_tag_directory.sv
sv/lrutd_checker.sv
test/tb.sv
